// ----- hdl/tpfcr_pkg.sv -----
// Shared types, constants and the microcode table of the two-phase flow cell residual core.
// Used by two_phase_flow_cell_residual_core and its checker; depends on nothing else.
package tpfcr_pkg;

   localparam int DATA_W = 32;
   localparam int PC_W   = 6;
   localparam int ADDR_W = 5;

   typedef logic signed [DATA_W-1:0]   word_type;
   typedef logic signed [2*DATA_W-1:0] wide_type;

   localparam wide_type WIDE_MAX = (wide_type'(1) <<< (DATA_W - 1)) - wide_type'(1);
   localparam wide_type WIDE_MIN = -WIDE_MAX - wide_type'(1);
   localparam word_type WORD_MAX = word_type'(WIDE_MAX);
   localparam word_type WORD_MIN = word_type'(WIDE_MIN);

   typedef enum logic [2:0] {
      REG_POROSITY    = 3'd0,
      REG_TIME_STEP   = 3'd1,
      REG_WET_GAIN    = 3'd2,
      REG_NONWET_GAIN = 3'd3,
      REG_LEFT_SAT    = 3'd4,
      REG_LEFT_VEL    = 3'd5,
      REG_LEFT_PRES   = 3'd6,
      REG_INV_WIDTH   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL_WB,
      ST_DIV
   } state_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MULQ,
      OP_MULI,
      OP_DIVQ,
      OP_DIVH,
      OP_END
   } op_type;

   typedef enum logic [4:0] {
      SRC_SAT,
      SRC_VEL,
      SRC_PRES,
      SRC_OLD_SAT,
      SRC_PERM,
      SRC_PREV_SAT,
      SRC_PREV_VEL,
      SRC_PREV_PRES,
      SRC_PREV_PERM,
      SRC_POROSITY,
      SRC_TIME_STEP,
      SRC_WET_GAIN,
      SRC_NONWET_GAIN,
      SRC_LEFT_SAT,
      SRC_LEFT_VEL,
      SRC_LEFT_PRES,
      SRC_INV_WIDTH,
      SRC_ONE,
      SRC_T_OM,
      SRC_T_A,
      SRC_T_B,
      SRC_T_W,
      SRC_T_LAM,
      SRC_T_FFS
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_T_OM,
      DST_T_A,
      DST_T_B,
      DST_T_W,
      DST_T_LAM,
      DST_T_FFS,
      DST_RES_SAT,
      DST_RES_VEL,
      DST_RES_PRES
   } dst_type;

   typedef struct packed {
      op_type  op;
      src_type a;
      src_type b;
      dst_type dst;
   } uop_type;

   localparam logic [PC_W-1:0] PC_CELL     = 6'd0;
   localparam logic [PC_W-1:0] PC_BOUNDARY = 6'd31;

   function automatic word_type sat_word(input wide_type x);
      word_type r;
      if (x > WIDE_MAX) begin
         r = WORD_MAX;
      end else if (x < WIDE_MIN) begin
         r = WORD_MIN;
      end else begin
         r = word_type'(x);
      end
      return r;
   endfunction

   function automatic uop_type mk_uop(input op_type op, input src_type a, input src_type b,
                                      input dst_type dst);
      uop_type u;
      u.op  = op;
      u.a   = a;
      u.b   = b;
      u.dst = dst;
      return u;
   endfunction

   // Interior cells run from PC_CELL, left boundary cells from PC_BOUNDARY.
   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         // Mobilities and wet fractional flow of the current cell.
         6'd0:  u = mk_uop(OP_SUB,  SRC_ONE,         SRC_SAT,       DST_T_OM);
         6'd1:  u = mk_uop(OP_MULQ, SRC_SAT,         SRC_SAT,       DST_T_A);
         6'd2:  u = mk_uop(OP_MULQ, SRC_WET_GAIN,    SRC_T_A,       DST_T_W);
         6'd3:  u = mk_uop(OP_MULQ, SRC_T_OM,        SRC_T_OM,      DST_T_B);
         6'd4:  u = mk_uop(OP_MULQ, SRC_NONWET_GAIN, SRC_T_B,       DST_T_B);
         6'd5:  u = mk_uop(OP_ADD,  SRC_T_W,         SRC_T_B,       DST_T_LAM);
         6'd6:  u = mk_uop(OP_DIVQ, SRC_T_W,         SRC_T_LAM,     DST_T_FFS);
         // Same for the previous cell.
         6'd7:  u = mk_uop(OP_SUB,  SRC_ONE,         SRC_PREV_SAT,  DST_T_OM);
         6'd8:  u = mk_uop(OP_MULQ, SRC_PREV_SAT,    SRC_PREV_SAT,  DST_T_A);
         6'd9:  u = mk_uop(OP_MULQ, SRC_WET_GAIN,    SRC_T_A,       DST_T_A);
         6'd10: u = mk_uop(OP_MULQ, SRC_T_OM,        SRC_T_OM,      DST_T_B);
         6'd11: u = mk_uop(OP_MULQ, SRC_NONWET_GAIN, SRC_T_B,       DST_T_B);
         6'd12: u = mk_uop(OP_ADD,  SRC_T_A,         SRC_T_B,       DST_T_B);
         6'd13: u = mk_uop(OP_DIVQ, SRC_T_A,         SRC_T_B,       DST_T_A);
         // Flux difference and saturation residual.
         6'd14: u = mk_uop(OP_MULQ, SRC_T_A,         SRC_PREV_VEL,  DST_T_A);
         6'd15: u = mk_uop(OP_MULQ, SRC_T_FFS,       SRC_VEL,       DST_T_B);
         6'd16: u = mk_uop(OP_SUB,  SRC_T_B,         SRC_T_A,       DST_T_B);
         6'd17: u = mk_uop(OP_MULI, SRC_TIME_STEP,   SRC_INV_WIDTH, DST_T_A);
         6'd18: u = mk_uop(OP_MULQ, SRC_T_A,         SRC_T_B,       DST_T_B);
         6'd19: u = mk_uop(OP_SUB,  SRC_SAT,         SRC_OLD_SAT,   DST_T_A);
         6'd20: u = mk_uop(OP_MULQ, SRC_POROSITY,    SRC_T_A,       DST_T_A);
         6'd21: u = mk_uop(OP_ADD,  SRC_T_A,         SRC_T_B,       DST_RES_SAT);
         // Harmonic mean permeability: the raw product stays in the multiplier register.
         6'd22: u = mk_uop(OP_MULQ, SRC_PERM,        SRC_PREV_PERM, DST_NONE);
         6'd23: u = mk_uop(OP_DIVH, SRC_PERM,        SRC_PREV_PERM, DST_T_A);
         6'd24: u = mk_uop(OP_MULQ, SRC_T_A,         SRC_T_LAM,     DST_T_A);
         6'd25: u = mk_uop(OP_SUB,  SRC_PRES,        SRC_PREV_PRES, DST_T_B);
         6'd26: u = mk_uop(OP_MULI, SRC_T_B,         SRC_INV_WIDTH, DST_T_B);
         6'd27: u = mk_uop(OP_MULQ, SRC_T_A,         SRC_T_B,       DST_T_A);
         6'd28: u = mk_uop(OP_ADD,  SRC_VEL,         SRC_T_A,       DST_RES_VEL);
         6'd29: u = mk_uop(OP_SUB,  SRC_VEL,         SRC_PREV_VEL,  DST_RES_PRES);
         6'd30: u = mk_uop(OP_END,  SRC_ONE,         SRC_ONE,       DST_NONE);
         // Left boundary cell.
         6'd31: u = mk_uop(OP_SUB,  SRC_SAT,         SRC_LEFT_SAT,  DST_RES_SAT);
         6'd32: u = mk_uop(OP_SUB,  SRC_VEL,         SRC_LEFT_VEL,  DST_RES_VEL);
         6'd33: u = mk_uop(OP_SUB,  SRC_PRES,        SRC_LEFT_PRES, DST_RES_PRES);
         default: u = mk_uop(OP_END, SRC_ONE,        SRC_ONE,       DST_NONE);
      endcase
      return u;
   endfunction

endpackage

// ----- hdl/two_phase_flow_cell_residual_core.sv -----
// Two-phase porous-flow cell residual core: microcoded sequencer around one multiplier,
// one saturating adder and a radix-2 divider. Depends on tpfcr_pkg.
//
// Usage: grid cells enter in order on the req stream, one word per cell, with tuser set
// for the left boundary cell. Each cell yields exactly one word of three residuals on
// the rsp stream. The core keeps the previous cell's saturation, velocity, pressure and
// permeability, so cells of one grid must arrive back to back in grid order.
// The user must write registers over the csr port only while no cell is in flight;
// the core does not enforce this. Per interior cell the sequencer runs three divisions
// on the shared one-bit-per-cycle divider, seventeen multiplies with a write-back state
// each, ten add or subtract steps and a final step that loads the output register. A
// division that saturates at once skips the divider and writes the largest word. A left
// boundary cell runs three subtract steps. A new cell is taken only once the last has
// left the sequencer; req_tready is high only while the sequencer is idle.
// The result word sits in an output register, so the next cell is taken and computed
// while the receiver stalls; only the final step of that cell waits for the register.
// Synchronous reset clears the sequencer, the previous-cell state and the output valid
// and loads the registers with their default values.
module two_phase_flow_cell_residual_core
   import tpfcr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // sat[31:0], vel[63:32], pres[95:64], old_sat[127:96], perm[158:128], zero pad
   input  logic [159:0]        req_tdata,
   // is_left_boundary[0]
   input  logic [0:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // res_sat[31:0], res_vel[63:32], res_pres[95:64]
   output logic [95:0]         rsp_tdata,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam word_type Q_ONE = word_type'(wide_type'(1) <<< FRAC_BITS);

   // Configuration registers
   logic [16:0]   porosity_ff, porosity_in;
   logic [30:0]   time_step_ff, time_step_in;
   logic [30:0]   wet_gain_ff, wet_gain_in;
   logic [30:0]   nonwet_gain_ff, nonwet_gain_in;
   word_type      left_sat_ff, left_sat_in;
   word_type      left_vel_ff, left_vel_in;
   word_type      left_pres_ff, left_pres_in;
   logic [11:0]   inv_width_ff, inv_width_in;

   logic          csr_wr;
   reg_index_type csr_idx;

   // Sequencer and previous-cell state
   state_type         state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   word_type          prev_sat_ff, prev_sat_in;
   word_type          prev_vel_ff, prev_vel_in;
   word_type          prev_pres_ff, prev_pres_in;
   logic [30:0]       prev_perm_ff, prev_perm_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Cell operands, temporaries and result words
   word_type    sat_ff, sat_in;
   word_type    vel_ff, vel_in;
   word_type    pres_ff, pres_in;
   word_type    old_sat_ff, old_sat_in;
   logic [30:0] perm_ff, perm_in;
   word_type    t_om_ff, t_om_in;
   word_type    t_a_ff, t_a_in;
   word_type    t_b_ff, t_b_in;
   word_type    t_w_ff, t_w_in;
   word_type    t_lam_ff, t_lam_in;
   word_type    t_ffs_ff, t_ffs_in;
   word_type    res_sat_ff, res_sat_in;
   word_type    res_vel_ff, res_vel_in;
   word_type    res_pres_ff, res_pres_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   // Shared multiplier and divider
   wide_type          prod_ff, prod_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   logic [DATA_W:0]   den_ff, den_in;
   logic [30:0]       num_ff, num_in;
   logic [30:0]       quo_ff, quo_in;
   logic [4:0]        cnt_ff, cnt_in;

   uop_type               uop;
   word_type              op_a;
   word_type              op_b;
   logic                  wr_en;
   word_type              wr_data;
   logic [2*DATA_W-1:0]   div_num;
   logic [DATA_W:0]       div_den;
   logic                  div_ovf;
   logic [DATA_W+1:0]     rem_shift;
   logic [DATA_W+1:0]     rem_next;
   logic                  div_ge;
   logic [30:0]           quo_next;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      porosity_in    = porosity_ff;
      time_step_in   = time_step_ff;
      wet_gain_in    = wet_gain_ff;
      nonwet_gain_in = nonwet_gain_ff;
      left_sat_in    = left_sat_ff;
      left_vel_in    = left_vel_ff;
      left_pres_in   = left_pres_ff;
      inv_width_in   = inv_width_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_POROSITY:    porosity_in    = csr_pwdata[16:0];
            REG_TIME_STEP:   time_step_in   = csr_pwdata[30:0];
            REG_WET_GAIN:    wet_gain_in    = csr_pwdata[30:0];
            REG_NONWET_GAIN: nonwet_gain_in = csr_pwdata[30:0];
            REG_LEFT_SAT:    left_sat_in    = word_type'(csr_pwdata);
            REG_LEFT_VEL:    left_vel_in    = word_type'(csr_pwdata);
            REG_LEFT_PRES:   left_pres_in   = word_type'(csr_pwdata);
            REG_INV_WIDTH:   inv_width_in   = csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_POROSITY:    csr_prdata = 32'(porosity_ff);
         REG_TIME_STEP:   csr_prdata = 32'(time_step_ff);
         REG_WET_GAIN:    csr_prdata = 32'(wet_gain_ff);
         REG_NONWET_GAIN: csr_prdata = 32'(nonwet_gain_ff);
         REG_LEFT_SAT:    csr_prdata = left_sat_ff;
         REG_LEFT_VEL:    csr_prdata = left_vel_ff;
         REG_LEFT_PRES:   csr_prdata = left_pres_ff;
         REG_INV_WIDTH:   csr_prdata = 32'(inv_width_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Operand selection
   // ------------------------------------------------------------------
   function automatic word_type pick(input src_type sel);
      word_type v;
      case (sel)
         SRC_SAT:         v = sat_ff;
         SRC_VEL:         v = vel_ff;
         SRC_PRES:        v = pres_ff;
         SRC_OLD_SAT:     v = old_sat_ff;
         SRC_PERM:        v = word_type'(perm_ff);
         SRC_PREV_SAT:    v = prev_sat_ff;
         SRC_PREV_VEL:    v = prev_vel_ff;
         SRC_PREV_PRES:   v = prev_pres_ff;
         SRC_PREV_PERM:   v = word_type'(prev_perm_ff);
         SRC_POROSITY:    v = word_type'(porosity_ff);
         SRC_TIME_STEP:   v = word_type'(time_step_ff);
         SRC_WET_GAIN:    v = word_type'(wet_gain_ff);
         SRC_NONWET_GAIN: v = word_type'(nonwet_gain_ff);
         SRC_LEFT_SAT:    v = left_sat_ff;
         SRC_LEFT_VEL:    v = left_vel_ff;
         SRC_LEFT_PRES:   v = left_pres_ff;
         SRC_INV_WIDTH:   v = word_type'(inv_width_ff);
         SRC_ONE:         v = Q_ONE;
         SRC_T_OM:        v = t_om_ff;
         SRC_T_A:         v = t_a_ff;
         SRC_T_B:         v = t_b_ff;
         SRC_T_W:         v = t_w_ff;
         SRC_T_LAM:       v = t_lam_ff;
         SRC_T_FFS:       v = t_ffs_ff;
         default:         v = '0;
      endcase
      return v;
   endfunction

   assign uop  = ucode(pc_ff);
   assign op_a = pick(uop.a);
   assign op_b = pick(uop.b);

   // Divider set-up. Every numerator and divisor here is non-negative. The quotient
   // saturates when it would not fit below 2^31, which also covers a zero divisor.
   always_comb begin
      if (uop.op == OP_DIVH) begin
         div_num = {prod_ff[2*DATA_W-2:0], 1'b0};
         div_den = {1'b0, op_a} + {1'b0, op_b};
      end else begin
         div_num = {{DATA_W{1'b0}}, op_a} << FRAC_BITS;
         div_den = {1'b0, op_b};
      end
      div_ovf = div_num[2*DATA_W-1:31] >= div_den;
   end

   assign rem_shift = {rem_ff, num_ff[30]};
   assign div_ge    = rem_shift >= {1'b0, den_ff};
   assign rem_next  = div_ge ? (rem_shift - {1'b0, den_ff}) : rem_shift;
   assign quo_next  = {quo_ff[29:0], div_ge};

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      prev_sat_in  = prev_sat_ff;
      prev_vel_in  = prev_vel_ff;
      prev_pres_in = prev_pres_ff;
      prev_perm_in = prev_perm_ff;
      rsp_valid_in = rsp_valid_ff;
      sat_in       = sat_ff;
      vel_in       = vel_ff;
      pres_in      = pres_ff;
      old_sat_in   = old_sat_ff;
      perm_in      = perm_ff;
      rsp_data_in  = rsp_data_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      wr_en        = 1'b0;
      wr_data      = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sat_in     = word_type'(req_tdata[31:0]);
               vel_in     = word_type'(req_tdata[63:32]);
               pres_in    = word_type'(req_tdata[95:64]);
               old_sat_in = word_type'(req_tdata[127:96]);
               perm_in    = req_tdata[158:128];
               pc_in      = req_tuser[0] ? PC_BOUNDARY : PC_CELL;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (uop.op)
               OP_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = sat_word(wide_type'(op_a) + wide_type'(op_b));
                  pc_in   = pc_ff + 1'b1;
               end
               OP_SUB: begin
                  wr_en   = 1'b1;
                  wr_data = sat_word(wide_type'(op_a) - wide_type'(op_b));
                  pc_in   = pc_ff + 1'b1;
               end
               OP_MULQ, OP_MULI: begin
                  prod_in  = wide_type'(op_a) * wide_type'(op_b);
                  state_in = ST_MUL_WB;
               end
               OP_DIVQ, OP_DIVH: begin
                  if (div_ovf) begin
                     wr_en   = 1'b1;
                     wr_data = WORD_MAX;
                     pc_in   = pc_ff + 1'b1;
                  end else begin
                     rem_in   = div_num[2*DATA_W-1:31];
                     num_in   = div_num[30:0];
                     den_in   = div_den;
                     quo_in   = '0;
                     cnt_in   = 5'd30;
                     state_in = ST_DIV;
                  end
               end
               OP_END: begin
                  // Wait here only while the previous word is still unclaimed.
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_data_in  = {res_pres_ff, res_vel_ff, res_sat_ff};
                     rsp_valid_in = 1'b1;
                     prev_sat_in  = sat_ff;
                     prev_vel_in  = vel_ff;
                     prev_pres_in = pres_ff;
                     prev_perm_in = perm_ff;
                     state_in     = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MUL_WB: begin
            wr_en = 1'b1;
            if (uop.op == OP_MULI) begin
               wr_data = sat_word(prod_ff);
            end else begin
               // Arithmetic shift gives the product rounded toward minus infinity.
               wr_data = sat_word(prod_ff >>> FRAC_BITS);
            end
            pc_in    = pc_ff + 1'b1;
            state_in = ST_EXEC;
         end
         ST_DIV: begin
            rem_in = rem_next[DATA_W:0];
            num_in = {num_ff[29:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               wr_en    = 1'b1;
               wr_data  = word_type'({1'b0, quo_next});
               pc_in    = pc_ff + 1'b1;
               state_in = ST_EXEC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      t_om_in     = t_om_ff;
      t_a_in      = t_a_ff;
      t_b_in      = t_b_ff;
      t_w_in      = t_w_ff;
      t_lam_in    = t_lam_ff;
      t_ffs_in    = t_ffs_ff;
      res_sat_in  = res_sat_ff;
      res_vel_in  = res_vel_ff;
      res_pres_in = res_pres_ff;
      if (wr_en) begin
         case (uop.dst)
            DST_T_OM:     t_om_in     = wr_data;
            DST_T_A:      t_a_in      = wr_data;
            DST_T_B:      t_b_in      = wr_data;
            DST_T_W:      t_w_in      = wr_data;
            DST_T_LAM:    t_lam_in    = wr_data;
            DST_T_FFS:    t_ffs_in    = wr_data;
            DST_RES_SAT:  res_sat_in  = wr_data;
            DST_RES_VEL:  res_vel_in  = wr_data;
            DST_RES_PRES: res_pres_in = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pc_ff          <= PC_CELL;
         rsp_valid_ff   <= 1'b0;
         prev_sat_ff    <= '0;
         prev_vel_ff    <= '0;
         prev_pres_ff   <= '0;
         prev_perm_ff   <= '0;
         porosity_ff    <= 17'd65536;
         time_step_ff   <= 31'd6554;
         wet_gain_ff    <= 31'd65536;
         nonwet_gain_ff <= 31'd19661;
         left_sat_ff    <= 32'sd65536;
         left_vel_ff    <= 32'sd6554;
         left_pres_ff   <= 32'sd65536;
         inv_width_ff   <= 12'd3;
      end else begin
         state_ff       <= state_in;
         pc_ff          <= pc_in;
         rsp_valid_ff   <= rsp_valid_in;
         prev_sat_ff    <= prev_sat_in;
         prev_vel_ff    <= prev_vel_in;
         prev_pres_ff   <= prev_pres_in;
         prev_perm_ff   <= prev_perm_in;
         porosity_ff    <= porosity_in;
         time_step_ff   <= time_step_in;
         wet_gain_ff    <= wet_gain_in;
         nonwet_gain_ff <= nonwet_gain_in;
         left_sat_ff    <= left_sat_in;
         left_vel_ff    <= left_vel_in;
         left_pres_ff   <= left_pres_in;
         inv_width_ff   <= inv_width_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff      <= sat_in;
      vel_ff      <= vel_in;
      pres_ff     <= pres_in;
      old_sat_ff  <= old_sat_in;
      perm_ff     <= perm_in;
      t_om_ff     <= t_om_in;
      t_a_ff      <= t_a_in;
      t_b_ff      <= t_b_in;
      t_w_ff      <= t_w_in;
      t_lam_ff    <= t_lam_in;
      t_ffs_ff    <= t_ffs_in;
      res_sat_ff  <= res_sat_in;
      res_vel_ff  <= res_vel_in;
      res_pres_ff <= res_pres_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/tpfcr_checker.sv -----
// Port-level checker for two_phase_flow_cell_residual_core, bound to the top level below.
// Imports tpfcr_pkg.
module tpfcr_checker
   import tpfcr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // Cells accepted whose result word has not been taken yet.
   logic [1:0] outstanding_ff, outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff;
      if ((req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (!(req_tvalid && req_tready) && (rsp_tvalid && rsp_tready)) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new word taken while a cell is being computed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (outstanding_ff == 2'd1 || outstanding_ff == 2'd2))
      else $error("result word without a matching input word");

endmodule

bind two_phase_flow_cell_residual_core tpfcr_checker u_tpfcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
